FILE: hw/rtl/llcs_pkg.sv
`timescale 1ns / 1ps

package llcs_pkg;

  // Default sizing
  localparam int unsigned DefMaxCells = 16;
  localparam int unsigned DefMaxProcs = 16;
  localparam int unsigned DefLoadBits = 10;

  // Fixed field widths
  localparam int unsigned KindW    = 3;
  localparam int unsigned CellIdW  = 5;
  localparam int unsigned PayloadW = 10;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned TallyW   = 16;
  localparam int unsigned ChosenW  = 6;
  localparam int unsigned OwnLoadW = 10;
  localparam int unsigned ResKindW = 2;

  typedef logic [KindW-1:0]    kind_t;
  typedef logic [ResKindW-1:0] res_kind_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  // Input item kinds
  localparam kind_t KindYearEnd = 3'd0;
  localparam kind_t KindFrogHop = 3'd1;
  localparam kind_t KindSpawn   = 3'd2;
  localparam kind_t KindLoadUpd = 3'd3;
  localparam kind_t KindAdopt   = 3'd4;

  // Result kinds
  localparam res_kind_t ResYearReport = 2'd0;
  localparam res_kind_t ResSurvey     = 2'd1;
  localparam res_kind_t ResSpawn      = 2'd2;
  localparam res_kind_t ResOwnLoad    = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t RegNumProcs = 2'd0;
  localparam cfg_idx_t RegOwnId    = 2'd1;
  localparam cfg_idx_t RegNumCells = 2'd2;

  // Configuration reset values
  localparam logic [CfgW-1:0] RstNumProcs = 5'd1;
  localparam logic [CfgW-1:0] RstOwnId    = 5'd1;
  localparam logic [CfgW-1:0] RstNumCells = 5'd16;

endpackage

FILE: hw/rtl/least_loaded_cell_selector_core.sv
`timescale 1ns / 1ps

// Least-loaded cell selector. Keeps a load table for cells 1..num_cells and
// saturating visit/infection tallies, and answers one item at a time: year
// end (report + clear tallies), frog hop (report, then count the visit and
// add the payload), load update (store a peer's load, no result), adopt
// (bump own load, broadcast it) and spawn query (pick the least-loaded group
// of cells by id mod num_procs, ties to the higher group, then its
// lowest-load cell, ties to the lower id; -1 if the group is empty).
// Sequencing: year end and frog hop stage their result in EXEC and reach
// the output register from EMIT; adopt reads in EXEC and writes back and
// stages in ADOPT first. Load update and unknown kinds free the input again
// from EXEC. The input reopens as the result moves to the output register.
// The load table has one read port, so a spawn query's walk reads one cell
// per cycle, and each group then drains its last read (skipped when the
// group is empty) and compares its sum; the result then leaves via EMIT.
// Input is taken whenever the sequencer is idle, even while a finished
// result still sits unclaimed in the output register. The load table reads
// as zero after reset through per-entry valid bits; there is no clearing
// pass. Configuration is expected only while the block is idle.
module least_loaded_cell_selector_core #(
  parameter int unsigned MAX_CELLS = llcs_pkg::DefMaxCells,
  parameter int unsigned MAX_PROCS = llcs_pkg::DefMaxProcs,
  parameter int unsigned LOAD_BITS = llcs_pkg::DefLoadBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  llcs_pkg::cfg_idx_t                    cfg_idx_i,
  input  logic [llcs_pkg::CfgW-1:0]             cfg_data_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [llcs_pkg::KindW-1:0]            kind_i,
  input  logic [llcs_pkg::CellIdW-1:0]          cell_id_i,
  input  logic [llcs_pkg::PayloadW-1:0]         payload_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [llcs_pkg::ResKindW-1:0]         result_kind_o,
  output logic [llcs_pkg::TallyW-1:0]           report_visits_o,
  output logic [llcs_pkg::TallyW-1:0]           report_infection_o,
  output logic signed [llcs_pkg::ChosenW-1:0]   chosen_cell_o,
  output logic [llcs_pkg::OwnLoadW-1:0]         own_load_o
);
  import llcs_pkg::*;

  localparam int unsigned AddrW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned IdW   = $clog2(MAX_CELLS + 1);
  localparam int unsigned PcW   = $clog2(MAX_PROCS + 1);
  localparam int unsigned GrpW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned WalkW = $clog2(MAX_CELLS + MAX_PROCS + 1);
  localparam int unsigned SumW  = LOAD_BITS + IdW;
  localparam logic [LOAD_BITS-1:0] LoadMax = '1;
  localparam logic [TallyW-1:0]    TallyMax = '1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_ADOPT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [CfgW-1:0] num_procs_q, own_id_q, num_cells_q;
  logic [IdW-1:0]  cells;
  logic [PcW-1:0]  procs;
  logic [IdW-1:0]  me;

  // captured item
  kind_t               kind_q;
  logic [CellIdW-1:0]  cid_q;
  logic [PayloadW-1:0] pay_q;

  // tallies
  logic [TallyW-1:0] visits_q, visits_d, infect_q, infect_d;

  // staged result
  res_kind_t            res_kind_q, res_kind_d;
  logic [TallyW-1:0]    res_vis_q, res_vis_d, res_inf_q, res_inf_d;
  logic [ChosenW-1:0]   res_cho_q, res_cho_d;
  logic [OwnLoadW-1:0]  res_own_q, res_own_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  res_kind_t            out_kind_q;
  logic [TallyW-1:0]    out_vis_q, out_inf_q;
  logic [ChosenW-1:0]   out_cho_q;
  logic [OwnLoadW-1:0]  out_own_q;
  logic                 out_load;

  // load table
  logic [LOAD_BITS-1:0] mem [MAX_CELLS];
  logic [MAX_CELLS-1:0] vld_q;
  logic                 we, re;
  logic [AddrW-1:0]     waddr, raddr;
  logic [LOAD_BITS-1:0] wdata;
  logic [LOAD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic [LOAD_BITS-1:0] rd_load;

  // spawn walk
  logic [GrpW-1:0]      grp_q, grp_d;
  logic [WalkW-1:0]     id_q, id_d;
  logic                 pend_q, pend_d;
  logic [IdW-1:0]       pend_id_q, pend_id_d;
  logic [SumW-1:0]      gsum_q, gsum_d;
  logic [IdW-1:0]       gbest_id_q, gbest_id_d;
  logic [LOAD_BITS-1:0] gbest_ld_q, gbest_ld_d;
  logic                 ghave_q, ghave_d;
  logic [SumW-1:0]      bsum_q, bsum_d;
  logic [IdW-1:0]       bid_q, bid_d;
  logic                 bhave_q, bhave_d;
  logic                 take_grp;
  logic [IdW-1:0]       fin_id;
  logic                 fin_have;

  // misc datapath
  logic [LOAD_BITS-1:0] pay_sat;
  logic [LOAD_BITS-1:0] adopt_ld;
  logic [TallyW:0]      inf_sum;
  logic                 cid_ok, own_ok;

  // ---------------------------------------------------------------------------
  // Effective configuration: zero acts as one, oversize clamps to the maximum
  // ---------------------------------------------------------------------------
  always_comb begin
    if (num_cells_q == '0) begin
      cells = IdW'(1);
    end else if (32'(num_cells_q) > 32'(MAX_CELLS)) begin
      cells = IdW'(MAX_CELLS);
    end else begin
      cells = IdW'(num_cells_q);
    end
    if (num_procs_q == '0) begin
      procs = PcW'(1);
    end else if (32'(num_procs_q) > 32'(MAX_PROCS)) begin
      procs = PcW'(MAX_PROCS);
    end else begin
      procs = PcW'(num_procs_q);
    end
  end

  assign own_ok = (own_id_q != '0) && (32'(own_id_q) <= 32'(cells));
  assign cid_ok = (cid_q != '0) && (32'(cid_q) <= 32'(cells));
  assign me     = own_ok ? IdW'(own_id_q) : cells;

  assign pay_sat  = (32'(pay_q) > 32'(LoadMax)) ? LoadMax : LOAD_BITS'(32'(pay_q));
  assign rd_load  = rd_vld_q ? rd_data_q : '0;
  assign adopt_ld = (rd_load == LoadMax) ? rd_load : rd_load + LOAD_BITS'(1);
  assign inf_sum  = {1'b0, infect_q} + (TallyW + 1)'(pay_q);

  // group finalize: ties go to the later (higher) group
  assign take_grp = (grp_q == '0) || (gsum_q <= bsum_q);
  assign fin_id   = take_grp ? gbest_id_q : bid_q;
  assign fin_have = take_grp ? ghave_q : bhave_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    visits_d   = visits_q;
    infect_d   = infect_q;
    res_kind_d = res_kind_q;
    res_vis_d  = res_vis_q;
    res_inf_d  = res_inf_q;
    res_cho_d  = res_cho_q;
    res_own_d  = res_own_q;
    grp_d      = grp_q;
    id_d       = id_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    gsum_d     = gsum_q;
    gbest_id_d = gbest_id_q;
    gbest_ld_d = gbest_ld_q;
    ghave_d    = ghave_q;
    bsum_d     = bsum_q;
    bid_d      = bid_q;
    bhave_d    = bhave_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_vis_d = '0;
        res_inf_d = '0;
        res_cho_d = '0;
        res_own_d = '0;
        unique case (kind_q)
          KindYearEnd: begin
            res_kind_d = ResYearReport;
            res_vis_d  = visits_q;
            res_inf_d  = infect_q;
            visits_d   = '0;
            infect_d   = '0;
            state_d    = S_EMIT;
          end
          KindFrogHop: begin
            res_kind_d = ResSurvey;
            res_vis_d  = visits_q;
            res_inf_d  = infect_q;
            visits_d   = (visits_q == TallyMax) ? visits_q : visits_q + TallyW'(1);
            infect_d   = inf_sum[TallyW] ? TallyMax : inf_sum[TallyW-1:0];
            state_d    = S_EMIT;
          end
          KindSpawn: begin
            grp_d   = '0;
            id_d    = WalkW'(procs);
            pend_d  = 1'b0;
            gsum_d  = '0;
            ghave_d = 1'b0;
            state_d = S_WALK;
          end
          KindLoadUpd: begin
            we      = cid_ok;
            waddr   = AddrW'(cid_q - CellIdW'(1));
            wdata   = pay_sat;
            state_d = S_IDLE;
          end
          KindAdopt: begin
            re      = 1'b1;
            raddr   = AddrW'(me - IdW'(1));
            state_d = S_ADOPT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_ADOPT: begin
        we         = 1'b1;
        waddr      = AddrW'(me - IdW'(1));
        wdata      = adopt_ld;
        res_kind_d = ResOwnLoad;
        res_own_d  = OwnLoadW'(32'(adopt_ld));
        state_d    = S_EMIT;
      end

      S_WALK: begin
        // fold in the entry read last cycle
        if (pend_q) begin
          gsum_d = gsum_q + SumW'(rd_load);
          if (!ghave_q || (rd_load < gbest_ld_q)) begin
            ghave_d    = 1'b1;
            gbest_id_d = pend_id_q;
            gbest_ld_d = rd_load;
          end
        end
        if (id_q <= WalkW'(cells)) begin
          re        = 1'b1;
          raddr     = AddrW'(id_q - WalkW'(1));
          pend_d    = 1'b1;
          pend_id_d = IdW'(id_q);
          id_d      = id_q + WalkW'(procs);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          bsum_d  = take_grp ? gsum_q : bsum_q;
          bid_d   = fin_id;
          bhave_d = fin_have;
          if (grp_q == GrpW'(procs - PcW'(1))) begin
            res_kind_d = ResSpawn;
            res_cho_d  = fin_have ? ChosenW'(32'(fin_id)) : '1;
            state_d    = S_EMIT;
          end else begin
            grp_d   = grp_q + GrpW'(1);
            id_d    = WalkW'(grp_q) + WalkW'(1);
            gsum_d  = '0;
            ghave_d = 1'b0;
          end
        end
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_procs_q <= RstNumProcs;
      own_id_q    <= RstOwnId;
      num_cells_q <= RstNumCells;
      visits_q    <= '0;
      infect_q    <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      visits_q    <= visits_d;
      infect_q    <= infect_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegNumProcs: num_procs_q <= cfg_data_i;
          RegOwnId:    own_id_q    <= cfg_data_i;
          RegNumCells: num_cells_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q <= kind_i;
      cid_q  <= cell_id_i;
      pay_q  <= payload_i;
    end
    res_kind_q <= res_kind_d;
    res_vis_q  <= res_vis_d;
    res_inf_q  <= res_inf_d;
    res_cho_q  <= res_cho_d;
    res_own_q  <= res_own_d;
    grp_q      <= grp_d;
    id_q       <= id_d;
    pend_id_q  <= pend_id_d;
    gsum_q     <= gsum_d;
    gbest_id_q <= gbest_id_d;
    gbest_ld_q <= gbest_ld_d;
    ghave_q    <= ghave_d;
    bsum_q     <= bsum_d;
    bid_q      <= bid_d;
    bhave_q    <= bhave_d;
    if (out_load) begin
      out_kind_q <= res_kind_q;
      out_vis_q  <= res_vis_q;
      out_inf_q  <= res_inf_q;
      out_cho_q  <= res_cho_q;
      out_own_q  <= res_own_q;
    end
  end

  // load table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign report_visits_o    = out_vis_q;
  assign report_infection_o = out_inf_q;
  assign chosen_cell_o      = $signed(out_cho_q);
  assign own_load_o         = out_own_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted item did not start execution");

  a_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (32'(grp_q) < 32'(procs)))
    else $error("group counter past group count");

  a_pend_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && pend_q) |-> (pend_id_q != '0 && 32'(pend_id_q) <= 32'(cells)))
    else $error("walk read outside cells in use");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("staged result not moved to output");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import llcs_pkg::*;

  // Pause before a config write: a spawn query with the largest table and
  // group count is the slowest item, and no-result items give no sign of
  // when they are done.
  localparam int unsigned DrainCycles = 60;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned StallLimit  = 4000;
  // Enough full-payload frog hops to pin the infection tally at its ceiling.
  localparam int unsigned TallyFlood  = 70;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PhaseItems  = 105;

  // Kinds and register indexes with no meaning in the block.
  localparam kind_t    KindFirstUnknown = 3'd5;
  localparam kind_t    KindLastUnknown  = 3'd7;
  localparam cfg_idx_t RegUnused        = 2'd3;

  typedef struct packed {
    kind_t                kind;
    logic [CellIdW-1:0]   cell_id;
    logic [PayloadW-1:0]  payload;
  } cell_msg_t;

  typedef struct packed {
    res_kind_t            kind;
    logic [TallyW-1:0]    visits;
    logic [TallyW-1:0]    infection;
    logic [ChosenW-1:0]   chosen;
    logic [OwnLoadW-1:0]  own_load;
  } reply_t;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        cfg_we   = 1'b0;
  cfg_idx_t                    cfg_idx  = RegNumProcs;
  logic [CfgW-1:0]             cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  kind_t                       kind     = KindYearEnd;
  logic [CellIdW-1:0]          cell_id  = '0;
  logic [PayloadW-1:0]         payload  = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ResKindW-1:0]         result_kind;
  logic [TallyW-1:0]           report_visits;
  logic [TallyW-1:0]           report_infection;
  logic signed [ChosenW-1:0]   chosen_cell;
  logic [OwnLoadW-1:0]         own_load;

  least_loaded_cell_selector_core dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (kind),
    .cell_id_i          (cell_id),
    .payload_i          (payload),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .result_kind_o      (result_kind),
    .report_visits_o    (report_visits),
    .report_infection_o (report_infection),
    .chosen_cell_o      (chosen_cell),
    .own_load_o         (own_load)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the block's table, tallies and registers.
  logic [DefLoadBits-1:0] cell_load [DefMaxCells];
  logic [TallyW-1:0]      visits    = '0;
  logic [TallyW-1:0]      infection = '0;
  logic [CfgW-1:0]        groups_cfg = RstNumProcs;
  logic [CfgW-1:0]        self_cfg   = RstOwnId;
  logic [CfgW-1:0]        cells_cfg  = RstNumCells;

  cell_msg_t   events_todo [$];   // items not yet offered to the block
  reply_t      replies_due [$];   // predicted results, oldest first
  int unsigned mismatch_count = 0;

  logic        in_taken    = 1'b0;
  bit          flood_mode  = 1'b0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  logic [31:0] stall_tick  = '0;
  stall_mode_e stall_mode  = StallNone;
  int unsigned idle_cycles = 0;

  initial begin
    for (int i = 0; i < DefMaxCells; i++) cell_load[i] = '0;
  end

  // Out-of-range register values clamp to the legal span.
  function automatic int unsigned live_cells();
    if (cells_cfg == 0) return 1;
    if (cells_cfg > DefMaxCells) return DefMaxCells;
    return cells_cfg;
  endfunction

  function automatic int unsigned live_groups();
    if (groups_cfg == 0) return 1;
    if (groups_cfg > DefMaxProcs) return DefMaxProcs;
    return groups_cfg;
  endfunction

  function automatic logic [TallyW-1:0] tally_add(logic [TallyW-1:0] base,
                                                  logic [TallyW-1:0] inc);
    logic [TallyW:0] total;
    total = base + inc;
    return total[TallyW] ? '1 : total[TallyW-1:0];
  endfunction

  // Least-loaded group (ties to the higher group), then its lightest cell
  // (ties to the lower id); an empty group answers all ones.
  function automatic logic [ChosenW-1:0] spawn_pick();
    int unsigned group_sum [DefMaxProcs];
    int unsigned low_id    [DefMaxProcs];
    int unsigned low_load  [DefMaxProcs];
    bit          seen      [DefMaxProcs];
    int unsigned g, pick;
    for (g = 0; g < DefMaxProcs; g++) begin
      group_sum[g] = 0;
      low_id[g]    = 0;
      low_load[g]  = 0;
      seen[g]      = 1'b0;
    end
    for (int unsigned id = 1; id <= live_cells(); id++) begin
      g = id % live_groups();
      group_sum[g] += cell_load[id-1];
      if (!seen[g] || cell_load[id-1] < low_load[g]) begin
        seen[g]     = 1'b1;
        low_id[g]   = id;
        low_load[g] = cell_load[id-1];
      end
    end
    pick = 0;
    for (g = 1; g < live_groups(); g++) begin
      if (group_sum[g] <= group_sum[pick]) pick = g;
    end
    return seen[pick] ? ChosenW'(low_id[pick]) : '1;
  endfunction

  // Advances the predictor by one item; returns 1 when a result is due.
  function automatic bit apply_event(input cell_msg_t m, output reply_t r);
    int unsigned home;
    r = '0;
    case (m.kind)
      KindYearEnd: begin
        r.kind      = ResYearReport;
        r.visits    = visits;
        r.infection = infection;
        visits      = '0;
        infection   = '0;
        return 1'b1;
      end
      KindFrogHop: begin
        r.kind      = ResSurvey;
        r.visits    = visits;
        r.infection = infection;
        visits      = tally_add(visits, TallyW'(1));
        infection   = tally_add(infection, TallyW'(m.payload));
        return 1'b1;
      end
      KindSpawn: begin
        r.kind   = ResSpawn;
        r.chosen = spawn_pick();
        return 1'b1;
      end
      KindLoadUpd: begin
        // bad peer ids drop silently; payload width equals the load width
        if (m.cell_id >= 1 && m.cell_id <= live_cells()) cell_load[m.cell_id-1] = m.payload;
        return 1'b0;
      end
      KindAdopt: begin
        home = (self_cfg >= 1 && self_cfg <= live_cells()) ? self_cfg : live_cells();
        if (cell_load[home-1] != '1) cell_load[home-1] = cell_load[home-1] + 1'b1;
        r.kind     = ResOwnLoad;
        r.own_load = cell_load[home-1];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(string name, logic signed [TallyW:0] want,
                             logic signed [TallyW:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: bursts of items with random gaps; in flood mode no gaps at all.
  always @(negedge clk) begin : drive_items
    cell_msg_t m;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // item still waiting, hold it
    end else if (gap_left != 0 && !flood_mode) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (events_todo.size() != 0) begin
      m = events_todo.pop_front();
      kind     <= m.kind;
      cell_id  <= m.cell_id;
      payload  <= m.payload;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver back-pressure: a new stall pattern whenever the low byte of the tick counter wraps to zero.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[7:0] == 8'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= stall_tick[2];
    endcase
  end

  // Monitor: check the result first, then predict for the item taken at
  // this same edge (it cannot be the one leaving).
  always @(posedge clk) begin : watch_block
    cell_msg_t m;
    reply_t    want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (replies_due.size() == 0) begin
          $error("result item with nothing outstanding (kind %0d)", result_kind);
          mismatch_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("report_visits", want.visits, report_visits);
          check_field("report_infection", want.infection, report_infection);
          check_field("chosen_cell", $signed(want.chosen), chosen_cell);
          check_field("own_load", want.own_load, own_load);
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        m.kind    = kind;
        m.cell_id = cell_id;
        m.payload = payload;
        if (apply_event(m, want)) replies_due.push_back(want);
      end
    end
    in_taken <= in_valid && (in_stall === 1'b0);
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_msg(kind_t k, logic [CellIdW-1:0] c, logic [PayloadW-1:0] p);
    cell_msg_t m;
    m.kind    = k;
    m.cell_id = c;
    m.payload = p;
    events_todo.push_back(m);
  endtask

  // Sender holds off until the block has delivered everything and gone quiet.
  task automatic settle();
    while (events_todo.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegNumProcs: groups_cfg = val;
      RegOwnId:    self_cfg   = val;
      RegNumCells: cells_cfg  = val;
      default: ;
    endcase
  endtask

  // Mostly legal values, with the edges and the clamped ranges well represented.
  function automatic logic [CfgW-1:0] pick_reg_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CfgW'($urandom_range(DefMaxCells + 1, 31));
      2:       return 5'd1;
      3:       return 5'd16;
      default: return CfgW'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic random_batch(int unsigned count);
    cell_msg_t   m;
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10)      m.kind = KindYearEnd;
      else if (r < 35) m.kind = KindFrogHop;
      else if (r < 55) m.kind = KindSpawn;
      else if (r < 80) m.kind = KindLoadUpd;
      else if (r < 95) m.kind = KindAdopt;
      else             m.kind = kind_t'($urandom_range(KindFirstUnknown, KindLastUnknown));
      // mostly valid peers, some out of range
      if ($urandom_range(0, 7) == 0) m.cell_id = CellIdW'($urandom_range(0, 31));
      else                           m.cell_id = CellIdW'($urandom_range(1, live_cells()));
      // small loads give plenty of ties in the spawn search
      case ($urandom_range(0, 5))
        0, 1:    m.payload = PayloadW'($urandom_range(0, 1023));
        2:       m.payload = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: m.payload = PayloadW'($urandom_range(0, 3));
      endcase
      events_todo.push_back(m);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset config (1 group, own id 1, 16 cells).
    push_msg(KindYearEnd, '0, '0);
    push_msg(KindFrogHop, 5'd1, '0);
    push_msg(KindFrogHop, 5'd2, '1);
    push_msg(KindFrogHop, 5'd3, 10'h155);
    push_msg(KindFrogHop, 5'd4, 10'h2AA);
    push_msg(KindYearEnd, '1, '1);
    push_msg(KindSpawn, '0, '0);
    push_msg(KindLoadUpd, 5'd16, '1);
    push_msg(KindLoadUpd, 5'd0, 10'd5);       // id zero: dropped
    push_msg(KindLoadUpd, '1, 10'd7);         // beyond the table: dropped
    push_msg(KindAdopt, '0, '0);
    push_msg(KindLoadUpd, 5'd1, 10'd1022);
    push_msg(KindAdopt, '0, '0);
    push_msg(KindAdopt, '0, '0);              // pinned at the load ceiling
    push_msg(KindSpawn, 5'd7, 10'd9);
    for (int k = KindFirstUnknown; k <= KindLastUnknown; k++) push_msg(kind_t'(k), '1, '1);
    push_msg(KindLoadUpd, 5'd5, 10'h2AA);
    push_msg(KindSpawn, '0, '0);
    settle();

    // More groups than cells: empty groups tie at zero and win.
    write_reg(RegNumProcs, 5'd4);
    write_reg(RegNumCells, 5'd2);
    write_reg(RegOwnId, 5'd0);                // bad own id falls to last cell
    push_msg(KindSpawn, '0, '0);
    push_msg(KindAdopt, '0, '0);
    push_msg(KindLoadUpd, 5'd3, 10'd9);
    push_msg(KindSpawn, '0, '0);
    settle();

    // Zero counts act as one; unused register index is ignored.
    write_reg(RegNumProcs, 5'd0);
    write_reg(RegOwnId, '1);
    write_reg(RegNumCells, 5'd0);
    write_reg(RegUnused, 5'd5);
    push_msg(KindSpawn, '0, '0);
    push_msg(KindAdopt, '0, '0);
    settle();

    // Oversized counts clamp to the maximum.
    write_reg(RegNumProcs, '1);
    write_reg(RegNumCells, '1);
    write_reg(RegOwnId, 5'd16);
    push_msg(KindSpawn, '0, '0);
    push_msg(KindAdopt, '0, '0);
    push_msg(KindSpawn, '0, '0);
    settle();

    // Drive the infection tally into saturation, back to back.
    flood_mode = 1'b1;
    repeat (TallyFlood) push_msg(KindFrogHop, CellIdW'($urandom_range(0, 31)), '1);
    push_msg(KindFrogHop, '0, '1);
    push_msg(KindYearEnd, '0, '0);
    push_msg(KindFrogHop, '0, '0);
    settle();
    flood_mode = 1'b0;

    // Random phases, each under its own register settings.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if ($urandom_range(0, 3) == 0) write_reg(RegUnused, CfgW'($urandom_range(0, 31)));
      write_reg(RegNumProcs, pick_reg_value());
      write_reg(RegOwnId, pick_reg_value());
      write_reg(RegNumCells, pick_reg_value());
      random_batch(PhaseItems);
      settle();
    end

    if (replies_due.size() != 0) begin
      $error("%0d result items never arrived", replies_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
